@@ design/cbb_pkg.sv @@
// shared types and constants of the clipped frame-store blitter
`timescale 1ns / 1ps

package cbb_pkg;

    localparam int CMD_W      = 3;
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 8;
    localparam int SCREEN_W_D = 256;
    localparam int SCREEN_H_D = 128;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR       = 3'd0,
        CMD_SET_PIXEL   = 3'd1,
        CMD_READ_PIXEL  = 3'd2,
        CMD_FILL_RECT   = 3'd3,
        CMD_BLIT_START  = 3'd4,
        CMD_BLIT_PIXEL  = 3'd5
    } t_cmd;

endpackage

@@ design/cbb_store.sv @@
// frame store memory: one write port, one read port, registered read data
`timescale 1ns / 1ps

module cbb_store #(
    parameter int DEPTH = cbb_pkg::SCREEN_W_D * cbb_pkg::SCREEN_H_D,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [cbb_pkg::PIX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [cbb_pkg::PIX_W-1:0]  o_rdata
);
    import cbb_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/cbb_walker.sv @@
// rectangle walker: one pixel write per cycle over a clipped rectangle
`timescale 1ns / 1ps

module cbb_walker #(
    parameter int SCREEN_W = cbb_pkg::SCREEN_W_D,
    parameter int SCREEN_H = cbb_pkg::SCREEN_H_D,
    parameter int XW       = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1,
    parameter int YW       = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1,
    parameter int AW       = $clog2(SCREEN_W * SCREEN_H)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [XW-1:0]              i_x0,
    input  logic [YW-1:0]              i_y0,
    input  logic [XW-1:0]              i_xl,
    input  logic [YW-1:0]              i_yl,
    input  logic [cbb_pkg::PIX_W-1:0]  i_color,
    output logic                       o_busy,
    output logic [AW-1:0]              o_addr,
    output logic [cbb_pkg::PIX_W-1:0]  o_data
);
    import cbb_pkg::*;

    logic             r_busy;
    logic [AW-1:0]    r_base;
    logic [XW-1:0]    r_col;
    logic [YW-1:0]    r_row;
    logic [XW-1:0]    r_x0;
    logic [XW-1:0]    r_xl;
    logic [YW-1:0]    r_yl;
    logic [PIX_W-1:0] r_color;

    // reset starts a full-screen pass in black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_base  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_x0    <= '0;
            r_xl    <= XW'(SCREEN_W - 1);
            r_yl    <= YW'(SCREEN_H - 1);
            r_color <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_base  <= AW'(i_y0) * AW'(SCREEN_W);
            r_col   <= i_x0;
            r_row   <= i_y0;
            r_x0    <= i_x0;
            r_xl    <= i_xl;
            r_yl    <= i_yl;
            r_color <= i_color;
        end else if (r_busy) begin
            if (r_col == r_xl) begin
                r_col <= r_x0;
                if (r_row == r_yl) begin
                    r_busy <= 1'b0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_base <= r_base + AW'(SCREEN_W);
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_base + AW'(r_col);
    assign o_data = r_color;

endmodule

@@ design/clipped_framebuffer_blitter_core.sv @@
// top level of the clipped frame-store blitter
`timescale 1ns / 1ps

// read path: a taken read passes the issue stage, read data stage and result register
// throughput: set pixel and blit pixel one request per cycle while no clear or fill is
//   set up or walked; a read blocks further reads until its result has left; clear and
//   fill rect stall all requests, the walker owning the store's write port meanwhile
// reset: synchronous, active low; after it a clearing pass writes black to all
//   SCREEN_W*SCREEN_H entries, one per cycle, and no request is taken until it ends
module clipped_framebuffer_blitter_core #(
    parameter int SCREEN_W = cbb_pkg::SCREEN_W_D,
    parameter int SCREEN_H = cbb_pkg::SCREEN_H_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [cbb_pkg::CMD_W-1:0]           i_command,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_rect_width,
    input  logic signed [cbb_pkg::COORD_W-1:0]  i_rect_height,
    input  logic [cbb_pkg::PIX_W-1:0]           i_color,
    input  logic [cbb_pkg::PIX_W-1:0]           i_key_color,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cbb_pkg::PIX_W-1:0]           o_pixel_value
);
    import cbb_pkg::*;

    localparam int XW = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
    localparam int YW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
    localparam int AW = $clog2(SCREEN_W * SCREEN_H);
    localparam int EW = COORD_W + 2;   // coordinate sums and compares

    // what the request in the issue stage does to the store
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_FILL
    } t_op;

    t_cmd w_cmd;
    logic w_accept;

    // blit state
    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_size_x, r_size_y;
    logic signed [COORD_W-1:0] n_org_x, n_org_y, n_size_x, n_size_y;
    logic [PIX_W-1:0]          r_key, n_key;
    logic [COORD_W-1:0]        r_cur_col, r_cur_row, n_cur_col, n_cur_row;

    // issue stage
    t_op              r_s1_op, n_s1_op;
    logic [XW-1:0]    r_s1_x, n_s1_x, r_s1_xl, n_s1_xl;
    logic [YW-1:0]    r_s1_y, n_s1_y, r_s1_yl, n_s1_yl;
    logic [PIX_W-1:0] r_s1_color, n_s1_color;
    logic             r_s1_on, n_s1_on;

    // read data stage and result register
    logic             r_s2_vld;
    logic             r_s2_on;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_val;

    // pixel coordinate, own or sprite cursor based, and its on-screen test
    logic signed [EW-1:0] w_px, w_py;
    logic                 w_on;
    logic                 w_blit_active;
    logic [COORD_W-1:0]   w_col_inc;

    // rectangle clipping
    logic signed [EW-1:0] w_sx, w_sy, w_sum_x, w_sum_y, w_sum_x_m1, w_sum_y_m1;
    logic                 w_fill_ok;
    logic [XW-1:0]        w_fx0, w_fxl;
    logic [YW-1:0]        w_fy0, w_fyl;

    // store and walker connections
    logic             w_wlk_busy;
    logic [AW-1:0]    w_wlk_addr;
    logic [PIX_W-1:0] w_wlk_data;
    logic [AW-1:0]    w_s1_addr;
    logic             w_st_we;
    logic [AW-1:0]    w_st_waddr;
    logic [PIX_W-1:0] w_st_wdata;
    logic             w_st_re;
    logic [PIX_W-1:0] w_st_rdata;
    logic             w_rd_block;

    assign w_cmd = t_cmd'(i_command);

    // reads wait until no read is in flight and the result register is free;
    // everything waits while a fill or clear is being set up or walked
    assign w_rd_block = (r_s1_op == OP_READ) || r_s2_vld || (r_out_vld && i_stall);
    assign o_stall    = w_wlk_busy || (r_s1_op == OP_FILL)
                        || ((w_cmd == CMD_READ_PIXEL) && w_rd_block);
    assign w_accept   = i_valid && !o_stall;

    // sprite cursor still inside a positive-size sprite
    assign w_blit_active = (r_size_x > 0) && (r_size_y > 0)
                           && ($signed({1'b0, r_cur_row}) < r_size_y);
    assign w_col_inc     = r_cur_col + 1'b1;

    always_comb begin
        if (w_cmd == CMD_BLIT_PIXEL) begin
            w_px = EW'(r_org_x) + $signed({2'b00, r_cur_col});
            w_py = EW'(r_org_y) + $signed({2'b00, r_cur_row});
        end else begin
            w_px = EW'(i_pos_x);
            w_py = EW'(i_pos_y);
        end
    end

    assign w_on = (w_px >= 0) && (w_px < $signed(EW'(SCREEN_W)))
                  && (w_py >= 0) && (w_py < $signed(EW'(SCREEN_H)));

    // with positive size the clipped span is empty only when it starts past
    // the far edge or ends before the near one
    assign w_sx       = EW'(i_pos_x);
    assign w_sy       = EW'(i_pos_y);
    assign w_sum_x    = w_sx + EW'(i_rect_width);
    assign w_sum_y    = w_sy + EW'(i_rect_height);
    assign w_sum_x_m1 = w_sum_x - $signed(EW'(1));
    assign w_sum_y_m1 = w_sum_y - $signed(EW'(1));
    assign w_fill_ok  = (i_rect_width > 0) && (i_rect_height > 0)
                        && (w_sx < $signed(EW'(SCREEN_W))) && (w_sum_x > 0)
                        && (w_sy < $signed(EW'(SCREEN_H))) && (w_sum_y > 0);
    assign w_fx0 = i_pos_x[COORD_W-1] ? '0 : XW'(i_pos_x);
    assign w_fy0 = i_pos_y[COORD_W-1] ? '0 : YW'(i_pos_y);
    assign w_fxl = (w_sum_x > $signed(EW'(SCREEN_W))) ? XW'(SCREEN_W - 1) : XW'(w_sum_x_m1);
    assign w_fyl = (w_sum_y > $signed(EW'(SCREEN_H))) ? YW'(SCREEN_H - 1) : YW'(w_sum_y_m1);

    // request decode into the issue stage and blit state
    always_comb begin
        n_s1_op    = OP_NONE;
        n_s1_x     = XW'(w_px);
        n_s1_y     = YW'(w_py);
        n_s1_xl    = r_s1_xl;
        n_s1_yl    = r_s1_yl;
        n_s1_color = i_color;
        n_s1_on    = w_on;
        n_org_x    = r_org_x;
        n_org_y    = r_org_y;
        n_size_x   = r_size_x;
        n_size_y   = r_size_y;
        n_key      = r_key;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        if (w_accept) begin
            unique case (w_cmd)
                CMD_CLEAR: begin
                    n_s1_op = OP_FILL;
                    n_s1_x  = '0;
                    n_s1_y  = '0;
                    n_s1_xl = XW'(SCREEN_W - 1);
                    n_s1_yl = YW'(SCREEN_H - 1);
                end
                CMD_SET_PIXEL: begin
                    if (w_on) begin
                        n_s1_op = OP_WRITE;
                    end
                end
                CMD_READ_PIXEL: begin
                    n_s1_op = OP_READ;
                end
                CMD_FILL_RECT: begin
                    if (w_fill_ok) begin
                        n_s1_op = OP_FILL;
                    end
                    n_s1_x  = w_fx0;
                    n_s1_y  = w_fy0;
                    n_s1_xl = w_fxl;
                    n_s1_yl = w_fyl;
                end
                CMD_BLIT_START: begin
                    n_org_x   = i_pos_x;
                    n_org_y   = i_pos_y;
                    n_size_x  = i_rect_width;
                    n_size_y  = i_rect_height;
                    n_key     = i_key_color;
                    n_cur_col = '0;
                    n_cur_row = '0;
                end
                CMD_BLIT_PIXEL: begin
                    if (w_blit_active) begin
                        // keyed or off-screen pixels still move the cursor
                        if (w_on && (i_color != r_key)) begin
                            n_s1_op = OP_WRITE;
                        end
                        if ($signed({1'b0, w_col_inc}) >= r_size_x) begin
                            n_cur_col = '0;
                            n_cur_row = r_cur_row + 1'b1;
                        end else begin
                            n_cur_col = w_col_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op   <= OP_NONE;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_size_x  <= '0;
            r_size_y  <= '0;
            r_key     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else begin
            r_s1_op   <= n_s1_op;
            r_s2_vld  <= (r_s1_op == OP_READ);
            r_org_x   <= n_org_x;
            r_org_y   <= n_org_y;
            r_size_x  <= n_size_x;
            r_size_y  <= n_size_y;
            r_key     <= n_key;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            if (r_s2_vld) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_x     <= n_s1_x;
        r_s1_y     <= n_s1_y;
        r_s1_xl    <= n_s1_xl;
        r_s1_yl    <= n_s1_yl;
        r_s1_color <= n_s1_color;
        r_s1_on    <= n_s1_on;
        r_s2_on    <= r_s1_on;
        if (r_s2_vld) begin
            // off-screen reads return black
            r_out_val <= r_s2_on ? w_st_rdata : '0;
        end
    end

    // issue stage drives the store unless the walker owns the write port
    assign w_s1_addr  = AW'(r_s1_y) * AW'(SCREEN_W) + AW'(r_s1_x);
    assign w_st_we    = w_wlk_busy || (r_s1_op == OP_WRITE);
    assign w_st_waddr = w_wlk_busy ? w_wlk_addr : w_s1_addr;
    assign w_st_wdata = w_wlk_busy ? w_wlk_data : r_s1_color;
    assign w_st_re    = (r_s1_op == OP_READ) && r_s1_on;

    cbb_walker #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .XW       (XW),
        .YW       (YW),
        .AW       (AW)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_s1_op == OP_FILL),
        .i_x0    (r_s1_x),
        .i_y0    (r_s1_y),
        .i_xl    (r_s1_xl),
        .i_yl    (r_s1_yl),
        .i_color (r_s1_color),
        .o_busy  (w_wlk_busy),
        .o_addr  (w_wlk_addr),
        .o_data  (w_wlk_data)
    );

    cbb_store #(
        .DEPTH (SCREEN_W * SCREEN_H),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (w_st_re),
        .i_raddr (w_s1_addr),
        .o_rdata (w_st_rdata)
    );

    assign o_valid       = r_out_vld;
    assign o_pixel_value = r_out_val;

endmodule

@@ design/cbb_checker.sv @@
// port-level checker for the blitter core and its bind
`timescale 1ns / 1ps

module cbb_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [cbb_pkg::CMD_W-1:0]           i_command,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [cbb_pkg::PIX_W-1:0]           o_pixel_value
);
    import cbb_pkg::*;

    logic w_rd_acc;
    assign w_rd_acc = i_valid && !o_stall && (i_command == CMD_READ_PIXEL);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_value)))
        else $error("stalled result changed");

    // every accepted read shows its result after the issue, read data and result stages
    a_rd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_acc |-> ##3 o_valid)
        else $error("read result missing");

    // a result appears only after a read request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_rd_acc, 3))
        else $error("result without read request");

    // a read is not taken while the result register is full and stalled
    a_rd_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && (i_command == CMD_READ_PIXEL)) |-> o_stall)
        else $error("read accepted with blocked result");

endmodule

bind clipped_framebuffer_blitter_core cbb_checker u_cbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel_value (o_pixel_value)
);

@@ tb/tb.sv @@
// self-checking bench for the clipped frame-store blitter, built around a shadow frame store
`timescale 1ns / 1ps

module tb;
    import cbb_pkg::*;

    localparam int SCR_W        = SCREEN_W_D;
    localparam int SCR_H        = SCREEN_H_D;
    localparam int ITEMS        = 1400;
    localparam int MAX_CYCLES   = 3_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_CLEARS   = 6;
    localparam int MAX_BIG_FILL = 6;
    localparam int SCRIPT_LEN   = 27;

    // command codes the block has no use for
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [CMD_W-1:0]           i_command;
    logic signed [COORD_W-1:0]  i_pos_x;
    logic signed [COORD_W-1:0]  i_pos_y;
    logic signed [COORD_W-1:0]  i_rect_width;
    logic signed [COORD_W-1:0]  i_rect_height;
    logic [PIX_W-1:0]           i_color;
    logic [PIX_W-1:0]           i_key_color;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [PIX_W-1:0]           o_pixel_value;

    clipped_framebuffer_blitter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_color       (i_color),
        .i_key_color   (i_key_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value)
    );

    // shadow copy of the frame store and of the sprite cursor
    logic [PIX_W-1:0] shadow_fb [SCR_W*SCR_H];
    int               spr_org_x, spr_org_y, spr_w, spr_h, spr_col, spr_row;
    logic [PIX_W-1:0] spr_key;

    // pixel values still owed by the block, oldest read first
    logic [PIX_W-1:0] pending_reads [$];

    bit idle_en = 1'b1;   // random idling on both sides
    bit hold_go = 1'b0;   // asks the receiver for one long hold-off
    int errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    int n_by_cmd [8];
    int n_big_fill = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    // directed script row; 'known' marks a row whose read value is typed in
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
        logic [PIX_W-1:0]          color;
        logic [PIX_W-1:0]          key;
        logic                      known;
        logic [PIX_W-1:0]          want;
    } t_script_row;

    t_script_row script_rows [SCRIPT_LEN] = '{
        // sprite pixel with no sprite started: size is zero, dropped
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h99, 8'h00, 1'b0, 8'h00},
        // black after the clearing pass, and black off screen at the extremes
        '{CMD_READ_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h00},
        '{CMD_READ_PIXEL, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF, 1'b1, 8'h00},
        // bottom right corner written and read back
        '{CMD_SET_PIXEL, 16'sd255, 16'sd127, 16'sd0, 16'sd0, 8'hFF, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd255, 16'sd127, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'hFF},
        // set pixel left of the screen is dropped
        '{CMD_SET_PIXEL, -16'sd1, 16'sd5, 16'sd0, 16'sd0, 8'hAA, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h00},
        '{CMD_SPARE_6, 16'sd1, 16'sd1, 16'sd4, 16'sd4, 8'h12, 8'h34, 1'b0, 8'h00},
        // rectangle hanging over the top left corner, clipped to 4x4
        '{CMD_FILL_RECT, -16'sd4, -16'sd4, 16'sd8, 16'sd8, 8'h55, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h55},
        '{CMD_READ_PIXEL, 16'sd4, 16'sd4, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h00},
        // most negative width draws nothing
        '{CMD_FILL_RECT, 16'sd10, 16'sd10, 16'h8000, 16'sd5, 8'h77, 8'h00, 1'b0, 8'h00},
        // huge rectangle that still ends left of and above the screen
        '{CMD_FILL_RECT, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hEE, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h00},
        // 3x2 sprite over the bottom right corner, key 0x11, one pixel too many
        '{CMD_BLIT_START, 16'sd254, 16'sd126, 16'sd3, 16'sd2, 8'h00, 8'h11, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h22, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h11, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h33, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h44, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h55, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h66, 8'h00, 1'b0, 8'h00},
        '{CMD_BLIT_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h77, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd254, 16'sd126, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h22},
        '{CMD_READ_PIXEL, 16'sd255, 16'sd127, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h55},
        // whole-screen clear
        '{CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h00, 1'b0, 8'h00},
        '{CMD_READ_PIXEL, 16'sd128, 16'sd64, 16'sd0, 16'sd0, 8'h00, 8'h00, 1'b1, 8'h80},
        '{CMD_SPARE_7, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 1'b0, 8'h00}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("%0t: run stopped after %0d cycles", $time, cycles);
            $display("[clipped_framebuffer_blitter_core] ERROR");
            $finish;
        end
    end

    function automatic bit in_frame(input int x, input int y);
        return x >= 0 && y >= 0 && x < SCR_W && y < SCR_H;
    endfunction

    // advances the shadow frame by one request, returns the pixel a read sees
    function automatic logic [PIX_W-1:0] shadow_apply(input logic [CMD_W-1:0] cmd,
            input int x, input int y, input int w, input int h,
            input logic [PIX_W-1:0] color, input logic [PIX_W-1:0] key);
        int x0, y0, x1, y1, dx, dy;
        logic [PIX_W-1:0] seen;
        seen = '0;
        case (cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < SCR_W * SCR_H; i++) shadow_fb[i] = color;
            end
            CMD_SET_PIXEL: begin
                if (in_frame(x, y)) shadow_fb[y * SCR_W + x] = color;
            end
            CMD_READ_PIXEL: begin
                if (in_frame(x, y)) seen = shadow_fb[y * SCR_W + x];
            end
            CMD_FILL_RECT: begin
                // clip to the screen; an empty span leaves both loops idle
                if (w > 0 && h > 0) begin
                    x0 = x < 0 ? 0 : x;
                    y0 = y < 0 ? 0 : y;
                    x1 = x + w > SCR_W ? SCR_W : x + w;
                    y1 = y + h > SCR_H ? SCR_H : y + h;
                    for (int r = y0; r < y1; r++)
                        for (int q = x0; q < x1; q++) shadow_fb[r * SCR_W + q] = color;
                end
            end
            CMD_BLIT_START: begin
                spr_org_x = x;
                spr_org_y = y;
                spr_w     = w;
                spr_h     = h;
                spr_key   = key;
                spr_col   = 0;
                spr_row   = 0;
            end
            CMD_BLIT_PIXEL: begin
                // dropped for an empty sprite or once the last row has passed
                if (spr_w > 0 && spr_h > 0 && spr_row < spr_h) begin
                    dx = spr_org_x + spr_col;
                    dy = spr_org_y + spr_row;
                    if (color != spr_key && in_frame(dx, dy)) shadow_fb[dy * SCR_W + dx] = color;
                    spr_col++;
                    if (spr_col >= spr_w) begin
                        spr_col = 0;
                        spr_row++;
                    end
                end
            end
            default: ;
        endcase
        return seen;
    endfunction

    // one request: optional idle gap, then hold it until the block takes it
    task automatic push_req(input logic [CMD_W-1:0] cmd, input int x, input int y,
            input int w, input int h, input logic [PIX_W-1:0] color,
            input logic [PIX_W-1:0] key, input bit known, input logic [PIX_W-1:0] want);
        int gaps;
        logic signed [COORD_W-1:0] xs, ys, ws, hs;
        logic [PIX_W-1:0] seen;
        gaps = 0;
        xs = x[COORD_W-1:0];
        ys = y[COORD_W-1:0];
        ws = w[COORD_W-1:0];
        hs = h[COORD_W-1:0];
        if (idle_en) begin
            while ($urandom_range(99) < 17) gaps++;
        end
        if (gaps > 0) begin
            i_valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_pos_x       <= xs;
        i_pos_y       <= ys;
        i_rect_width  <= ws;
        i_rect_height <= hs;
        i_color       <= color;
        i_key_color   <= key;
        do @(posedge i_clk); while (o_stall);
        // taken at this edge: the shadow sees the same 16-bit values as the block
        seen = shadow_apply(cmd, xs, ys, ws, hs, color, key);
        if (cmd == CMD_READ_PIXEL) pending_reads.push_back(known ? want : seen);
        n_by_cmd[cmd]++;
        if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) n_sent++;
    endtask

    task automatic rand_req(input logic [CMD_W-1:0] cmd, input int x, input int y,
            input int w, input int h, input logic [PIX_W-1:0] color,
            input logic [PIX_W-1:0] key);
        push_req(cmd, x, y, w, h, color, key, 1'b0, 8'h00);
    endtask

    function automatic int any16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic logic [PIX_W-1:0] any_pix();
        return PIX_W'($urandom_range(255));
    endfunction

    // coordinate biased toward the screen edges, with some off screen
    function automatic int pick_coord(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(15);
        if (r < 60) return span - 1 - int'($urandom_range(15));
        if (r < 80) return $urandom_range(span - 1);
        if (r < 92) return ($urandom_range(1) ? span : 0) + int'($urandom_range(15)) - 8;
        return any16();
    endfunction

    // mostly small sizes; 'wild' lets in the full 16-bit range
    function automatic int pick_size(input bit wild);
        int r;
        r = $urandom_range(99);
        if (wild && r < 50) return any16();
        if (r < 10) return -int'($urandom_range(3));
        if (r < 13) return -32768;
        return 1 + int'($urandom_range(7));
    endfunction

    // receiver: checks each result against the oldest owed read, then picks next stall
    always @(posedge i_clk) begin : result_side
        logic [PIX_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: pixel_value %02h with no read pending, expected none",
                         $time, o_pixel_value);
                errors++;
            end else begin
                want = pending_reads.pop_front();
                n_checked++;
                if (o_pixel_value !== want) begin
                    $display("%0t: pixel_value mismatch, expected %02h, actual %02h",
                             $time, want, o_pixel_value);
                    errors++;
                end
            end
        end
        // one long hold-off so reads back up and the block stalls its input
        if (hold_go && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_en && ($urandom_range(99) < 17);
        end
    end

    initial begin : stimulus
        int r, n, q, cnt;
        int ox, oy, sw, sh, fx, fy, fw, fh;
        int sx [4];
        int sy [4];
        int n_clears;
        bit wild;
        logic [PIX_W-1:0] key, pc;

        n_clears = 0;
        for (int i = 0; i < 8; i++) n_by_cmd[i] = 0;
        for (int i = 0; i < SCR_W * SCR_H; i++) shadow_fb[i] = '0;
        spr_org_x = 0;
        spr_org_y = 0;
        spr_w     = 0;
        spr_h     = 0;
        spr_col   = 0;
        spr_row   = 0;
        spr_key   = '0;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_CLEAR;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_rect_width  <= '0;
        i_rect_height <= '0;
        i_color       <= '0;
        i_key_color   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed script; the block holds off requests through its clearing pass
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            push_req(script_rows[i].cmd, script_rows[i].x, script_rows[i].y,
                     script_rows[i].w, script_rows[i].h, script_rows[i].color,
                     script_rows[i].key, script_rows[i].known, script_rows[i].want);
        end

        // back-pressure: sets and read-backs keep coming while results are held
        hold_go <= 1'b1;
        for (int i = 0; i < 20; i++) begin
            ox = pick_coord(SCR_W);
            oy = pick_coord(SCR_H);
            rand_req(CMD_SET_PIXEL, ox, oy, any16(), any16(), any_pix(), any_pix());
            rand_req(CMD_READ_PIXEL, ox, oy, any16(), any16(), any_pix(), any_pix());
        end

        // random scenes, with a stretch in the middle where nobody idles
        while (n_sent < ITEMS) begin
            idle_en <= !(n_sent >= 600 && n_sent < 900);
            r = $urandom_range(99);
            if (r < 35) begin
                // sprite: start, stream of pixels with some keyed, then read-back
                ox   = pick_coord(SCR_W);
                oy   = pick_coord(SCR_H);
                wild = ($urandom_range(19) == 0);
                sw   = pick_size(wild);
                sh   = pick_size(wild);
                key  = any_pix();
                rand_req(CMD_BLIT_START, ox, oy, sw, sh, any_pix(), key);
                if (sw > 0 && sh > 0 && sw <= 64 && sh <= 64 && sw * sh <= 64) n = sw * sh;
                else n = $urandom_range(12, 1);
                q = $urandom_range(99);
                if (q < 15) n += 1 + int'($urandom_range(3));
                else if (q < 30 && n > 1) n = 1 + int'($urandom_range(n - 2));
                for (int i = 0; i < n; i++) begin
                    pc = ($urandom_range(3) == 0) ? key : any_pix();
                    rand_req(CMD_BLIT_PIXEL, any16(), any16(), any16(), any16(), pc, any_pix());
                end
                cnt = 1 + int'($urandom_range(3));
                for (int i = 0; i < cnt; i++) begin
                    if (sw > 0 && sh > 0 && sw <= 64 && sh <= 64) begin
                        rand_req(CMD_READ_PIXEL, ox + int'($urandom_range(sw - 1)),
                                 oy + int'($urandom_range(sh - 1)), any16(), any16(),
                                 any_pix(), any_pix());
                    end else begin
                        rand_req(CMD_READ_PIXEL, pick_coord(SCR_W), pick_coord(SCR_H),
                                 any16(), any16(), any_pix(), any_pix());
                    end
                end
            end else if (r < 52) begin
                // a few pixel sets, then read each one back
                cnt = 1 + int'($urandom_range(3));
                for (int i = 0; i < cnt; i++) begin
                    sx[i] = pick_coord(SCR_W);
                    sy[i] = pick_coord(SCR_H);
                    rand_req(CMD_SET_PIXEL, sx[i], sy[i], any16(), any16(), any_pix(), any_pix());
                end
                for (int i = 0; i < cnt; i++) begin
                    rand_req(CMD_READ_PIXEL, sx[i], sy[i], any16(), any16(), any_pix(), any_pix());
                end
            end else if (r < 67) begin
                // rectangle, rarely of any size, then probe its corners and just outside
                fx = pick_coord(SCR_W);
                fy = pick_coord(SCR_H);
                if (n_big_fill < MAX_BIG_FILL && $urandom_range(24) == 0) begin
                    fw = any16();
                    fh = any16();
                    n_big_fill++;
                end else begin
                    fw = pick_size(1'b0);
                    fh = pick_size(1'b0);
                end
                rand_req(CMD_FILL_RECT, fx, fy, fw, fh, any_pix(), any_pix());
                rand_req(CMD_READ_PIXEL, fx, fy, any16(), any16(), any_pix(), any_pix());
                rand_req(CMD_READ_PIXEL, fx + fw - 1, fy + fh - 1, any16(), any16(),
                         any_pix(), any_pix());
                rand_req(CMD_READ_PIXEL, fx + fw, fy - 1, any16(), any16(), any_pix(), any_pix());
            end else if (r < 90) begin
                cnt = 1 + int'($urandom_range(4));
                for (int i = 0; i < cnt; i++) begin
                    rand_req(CMD_READ_PIXEL, pick_coord(SCR_W), pick_coord(SCR_H),
                             any16(), any16(), any_pix(), any_pix());
                end
            end else if (r < 92 && n_clears < MAX_CLEARS) begin
                // clears are slow, so only a handful, color at either extreme or random
                q  = $urandom_range(2);
                pc = (q == 0) ? 8'h00 : (q == 1) ? 8'hFF : any_pix();
                rand_req(CMD_CLEAR, any16(), any16(), any16(), any16(), pc, any_pix());
                n_clears++;
                rand_req(CMD_READ_PIXEL, pick_coord(SCR_W), pick_coord(SCR_H),
                         any16(), any16(), any_pix(), any_pix());
            end else begin
                // noise: spare codes, stray sprite pixels, empty sprites
                q = $urandom_range(3);
                if (q == 0) begin
                    rand_req(CMD_SPARE_6, any16(), any16(), any16(), any16(), any_pix(), any_pix());
                end else if (q == 1) begin
                    rand_req(CMD_SPARE_7, any16(), any16(), any16(), any16(), any_pix(), any_pix());
                end else if (q == 2) begin
                    rand_req(CMD_BLIT_PIXEL, any16(), any16(), any16(), any16(), any_pix(),
                             any_pix());
                end else begin
                    rand_req(CMD_BLIT_START, pick_coord(SCR_W), pick_coord(SCR_H),
                             -int'($urandom_range(3)), pick_size(1'b0), any_pix(), any_pix());
                    for (int i = 0; i < 3; i++) begin
                        rand_req(CMD_BLIT_PIXEL, any16(), any16(), any16(), any16(), any_pix(),
                                 any_pix());
                    end
                    rand_req(CMD_READ_PIXEL, pick_coord(SCR_W), pick_coord(SCR_H),
                             any16(), any16(), any_pix(), any_pix());
                end
            end
        end

        // drain: every read answered, then a short wait for anything stray
        i_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d reads checked, %0d pixel sets, %0d sprites, %0d sprite pixels",
                 n_sent, n_checked, n_by_cmd[CMD_SET_PIXEL], n_by_cmd[CMD_BLIT_START],
                 n_by_cmd[CMD_BLIT_PIXEL]);
        $display("plus %0d rect fills (%0d unbounded), %0d clears, %0d spare codes, %0d errors",
                 n_by_cmd[CMD_FILL_RECT], n_big_fill, n_by_cmd[CMD_CLEAR],
                 n_by_cmd[CMD_SPARE_6] + n_by_cmd[CMD_SPARE_7], errors);
        if (errors == 0) begin
            $display("[clipped_framebuffer_blitter_core] OK");
        end else begin
            $display("[clipped_framebuffer_blitter_core] ERROR");
        end
        $finish;
    end

endmodule
